[hdl/bmon_pkg.sv]
`default_nettype none

package bmon_pkg;

  localparam int CELL_MV_W  = 16;
  localparam int CURRENT_W  = 24;
  localparam int TEMP_W     = 16;
  localparam int FLAGS_W    = 8;
  localparam int SOC_W      = 7;
  localparam int CAP_W      = 31;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int PROD_W     = 38;
  localparam int STEP_W     = 5;
  localparam int REM10_W    = 4;

  localparam logic [STATUS_W-1:0] STATUS_IDLE        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CHARGING    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DISCHARGING = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FAULT       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_OVER_TEMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_UNDER_TEMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DSG_OVER_TEMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOC_FULL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOC_EMPTY      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_MASK       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DSG_MASK       = 3'd7;

  localparam logic [CAP_W-1:0]            RESET_CAPACITY     = 31'd360000000;
  localparam logic [CAP_W-1:0]            RESET_COUNTER      = 31'd180000000;
  localparam logic signed [TEMP_W-1:0]    RESET_CHG_OVER     = 16'sd450;
  localparam logic signed [TEMP_W-1:0]    RESET_CHG_UNDER    = 16'sd0;
  localparam logic signed [TEMP_W-1:0]    RESET_DSG_OVER     = 16'sd600;
  localparam logic [SOC_W-1:0]            RESET_SOC_FULL     = 7'd100;
  localparam logic [SOC_W-1:0]            RESET_SOC_EMPTY    = 7'd5;
  localparam logic [FLAGS_W-1:0]          RESET_CHG_MASK     = 8'd7;
  localparam logic [FLAGS_W-1:0]          RESET_DSG_MASK     = 8'd56;

  localparam logic signed [CURRENT_W-1:0] CURRENT_THRESHOLD  = 24'sd500;
  localparam logic [CELL_MV_W-1:0]        PACK_MV_MAX        = 16'hFFFF;
  localparam logic [REM10_W:0]            TICK_DIVISOR       = 5'd10;
  localparam logic [SOC_W-1:0]            SOC_SCALE          = 7'd100;

  typedef struct packed {
    logic [CAP_W-1:0]          capacity;
    logic signed [TEMP_W-1:0]  chg_over_temp;
    logic signed [TEMP_W-1:0]  chg_under_temp;
    logic signed [TEMP_W-1:0]  dsg_over_temp;
    logic [SOC_W-1:0]          soc_full;
    logic [SOC_W-1:0]          soc_empty;
    logic [FLAGS_W-1:0]        chg_mask;
    logic [FLAGS_W-1:0]        dsg_mask;
  } cfg_t;

  typedef struct packed {
    logic [CELL_MV_W-1:0]         pack_mv;
    logic signed [CURRENT_W-1:0]  current;
    logic signed [TEMP_W-1:0]     avg_temp;
    logic signed [TEMP_W-1:0]     max_temp;
    logic [SOC_W-1:0]             soc;
    logic [FLAGS_W-1:0]           flags;
    logic [STATUS_W-1:0]          status;
    logic                         valid;
  } held_t;

  typedef struct packed {
    logic [CELL_MV_W-1:0]      pack_mv;
    logic [SOC_W-1:0]          soc_pct;
    logic signed [TEMP_W-1:0]  avg_temp;
    logic signed [TEMP_W-1:0]  max_temp;
    logic [STATUS_W-1:0]       pack_status;
    logic                      charge_ok;
    logic                      discharge_ok;
    logic                      fault_active;
    logic                      state_valid;
  } result_t;

  function automatic result_t bmon_make_result(held_t h, cfg_t c);
    result_t r;
    r.pack_mv      = h.pack_mv;
    r.soc_pct      = h.soc;
    r.avg_temp     = h.avg_temp;
    r.max_temp     = h.max_temp;
    r.pack_status  = h.status;
    r.fault_active = |h.flags;
    r.state_valid  = h.valid;
    r.charge_ok    = !(|(h.flags & c.chg_mask)) && !(h.max_temp > c.chg_over_temp) &&
                     !(h.avg_temp < c.chg_under_temp) && !(h.soc >= c.soc_full);
    r.discharge_ok = !(|(h.flags & c.dsg_mask)) && !(h.max_temp > c.dsg_over_temp) &&
                     !(h.soc <= c.soc_empty);
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/bmon_if.sv]
`default_nettype none

interface bmon_in_if #(parameter int CELL_COUNT = 4);
  import bmon_pkg::*;

  logic                             valid;
  logic                             ready;
  logic                             afe_valid;
  logic [CELL_COUNT*CELL_MV_W-1:0]  cell_mv;
  logic signed [CURRENT_W-1:0]      pack_current;
  logic [FLAGS_W-1:0]               protection_flags;
  logic                             temp_valid;
  logic signed [TEMP_W-1:0]         temp_a;
  logic signed [TEMP_W-1:0]         temp_b;

  modport source (output valid, afe_valid, cell_mv, pack_current, protection_flags,
                  temp_valid, temp_a, temp_b, input ready);
  modport sink (input valid, afe_valid, cell_mv, pack_current, protection_flags,
                temp_valid, temp_a, temp_b, output ready);
endinterface

interface bmon_out_if;
  import bmon_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CELL_MV_W-1:0]      pack_mv;
  logic [SOC_W-1:0]          soc_pct;
  logic signed [TEMP_W-1:0]  avg_temp;
  logic signed [TEMP_W-1:0]  max_temp;
  logic [STATUS_W-1:0]       pack_status;
  logic                      charge_ok;
  logic                      discharge_ok;
  logic                      fault_active;
  logic                      state_valid;

  modport source (output valid, pack_mv, soc_pct, avg_temp, max_temp, pack_status,
                  charge_ok, discharge_ok, fault_active, state_valid, input ready);
  modport sink (input valid, pack_mv, soc_pct, avg_temp, max_temp, pack_status,
                charge_ok, discharge_ok, fault_active, state_valid, output ready);
endinterface

`default_nettype wire

[hdl/bmon_soc_div.sv]
`default_nettype none

module bmon_soc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bmon_pkg::CAP_W-1:0]  counter,
  input  wire logic [bmon_pkg::CAP_W-1:0]  capacity,
  output logic                             done,
  output logic [bmon_pkg::SOC_W-1:0]       quotient
);
  import bmon_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                zero_r, zero_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [PROD_W-1:0]   rem_r, rem_nxt;
  logic [PROD_W-1:0]   dvs_r, dvs_nxt;
  logic [SOC_W-1:0]    quo_r, quo_nxt;
  logic                ge;

  assign ge = rem_r >= dvs_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      zero_nxt = capacity == '0;
      step_nxt = '0;
      rem_nxt  = PROD_W'(counter) * PROD_W'(SOC_SCALE);
      dvs_nxt  = PROD_W'(capacity) << (SOC_W - 1);
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dvs_r;
      end
      quo_nxt  = {quo_r[SOC_W-2:0], ge & ~zero_r};
      dvs_nxt  = dvs_r >> 1;
      step_nxt = step_r + 3'd1;
      if (step_r == 3'(SOC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= zero_nxt;
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[hdl/battery_coulomb_soc_monitor_unit.sv]
`default_nettype none

// Battery pack monitor with coulomb counting, one transaction per 100 ms tick. A transaction
// with valid cell data holds the input off until its result has been registered: the pack
// current is divided by ten, one quotient bit per cycle (the cell voltages are summed one
// cell per cycle during the same cycles), then the charge counter is updated, then the state
// of charge division forms the counter times 100 and then produces one of seven quotient
// bits per cycle, and last the result is registered. A transaction with invalid cell data
// skips these steps and goes straight to the result register. The result is held in an
// output register, so a new transaction is taken while a result waits; the last step of the
// next transaction stretches until that waiting result has been taken.
module battery_coulomb_soc_monitor_unit #(
  parameter int CELL_COUNT = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  bmon_in_if.sink                               in_ch,
  bmon_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [bmon_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bmon_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bmon_pkg::*;

  localparam int CELLS_W = CELL_COUNT * CELL_MV_W;
  localparam int SUM_W   = CELL_MV_W + $clog2(CELL_COUNT);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_ACC  = 5'b00100,
    S_SOC  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  cfg_t                    cfg_r, cfg_nxt;
  held_t                   held_r, held_nxt;
  result_t                 out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    soc_start_r, soc_start_nxt;
  logic [CAP_W-1:0]        counter_r, counter_nxt;
  logic [CELLS_W-1:0]      cell_sr_r, cell_sr_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [CURRENT_W-1:0]    dsr_r, dsr_nxt;
  logic [REM10_W-1:0]      rem_r, rem_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;

  logic                    soc_done;
  logic [SOC_W-1:0]        soc_quo;
  logic [REM10_W:0]        trial;
  logic                    trial_ge;
  logic signed [TEMP_W:0]  temp_sum;
  logic signed [TEMP_W:0]  temp_adj;
  logic [CAP_W+1:0]        quo_ext;
  logic signed [CAP_W+1:0] cnt_sum;

  bmon_soc_div u_soc_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (soc_start_r),
    .counter  (counter_r),
    .capacity (cfg_r.capacity),
    .done     (soc_done),
    .quotient (soc_quo)
  );

  assign trial    = {rem_r, dsr_r[CURRENT_W-1]};
  assign trial_ge = trial >= TICK_DIVISOR;
  assign temp_sum = {in_ch.temp_a[TEMP_W-1], in_ch.temp_a} +
                    {in_ch.temp_b[TEMP_W-1], in_ch.temp_b};
  assign temp_adj = temp_sum + (TEMP_W+1)'(temp_sum[TEMP_W] & temp_sum[0]);
  assign quo_ext  = (CAP_W+2)'(dsr_r);
  assign cnt_sum  = $signed({2'b00, counter_r}) +
                    (held_r.current[CURRENT_W-1] ? -$signed(quo_ext) : $signed(quo_ext));

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY:       cfg_nxt.capacity       = cfg_data[CAP_W-1:0];
        CFG_CHG_OVER_TEMP:  cfg_nxt.chg_over_temp  = cfg_data[TEMP_W-1:0];
        CFG_CHG_UNDER_TEMP: cfg_nxt.chg_under_temp = cfg_data[TEMP_W-1:0];
        CFG_DSG_OVER_TEMP:  cfg_nxt.dsg_over_temp  = cfg_data[TEMP_W-1:0];
        CFG_SOC_FULL:       cfg_nxt.soc_full       = cfg_data[SOC_W-1:0];
        CFG_SOC_EMPTY:      cfg_nxt.soc_empty      = cfg_data[SOC_W-1:0];
        CFG_CHG_MASK:       cfg_nxt.chg_mask       = cfg_data[FLAGS_W-1:0];
        CFG_DSG_MASK:       cfg_nxt.dsg_mask       = cfg_data[FLAGS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    soc_start_nxt = 1'b0;
    counter_nxt   = counter_r;
    cell_sr_nxt   = cell_sr_r;
    sum_nxt       = sum_r;
    dsr_nxt       = dsr_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.afe_valid) begin
            held_nxt.current = in_ch.pack_current;
            held_nxt.flags   = in_ch.protection_flags;
            if (in_ch.temp_valid) begin
              held_nxt.avg_temp = temp_adj[TEMP_W:1];
              held_nxt.max_temp = (in_ch.temp_a > in_ch.temp_b) ? in_ch.temp_a : in_ch.temp_b;
            end
            if (in_ch.protection_flags != '0) begin
              held_nxt.status = STATUS_FAULT;
            end else if (in_ch.pack_current > CURRENT_THRESHOLD) begin
              held_nxt.status = STATUS_CHARGING;
            end else if (in_ch.pack_current < -CURRENT_THRESHOLD) begin
              held_nxt.status = STATUS_DISCHARGING;
            end else begin
              held_nxt.status = STATUS_IDLE;
            end
            held_nxt.valid = 1'b1;
            cell_sr_nxt    = in_ch.cell_mv;
            sum_nxt        = '0;
            dsr_nxt        = in_ch.pack_current[CURRENT_W-1] ? -in_ch.pack_current :
                                                               in_ch.pack_current;
            rem_nxt        = '0;
            step_nxt       = '0;
            state_nxt      = S_DIV;
          end else begin
            held_nxt.valid = 1'b0;
            state_nxt      = S_OUT;
          end
        end
      end
      S_DIV: begin
        sum_nxt     = sum_r + SUM_W'(cell_sr_r[CELL_MV_W-1:0]);
        cell_sr_nxt = cell_sr_r >> CELL_MV_W;
        rem_nxt     = trial_ge ? REM10_W'(trial - TICK_DIVISOR) : trial[REM10_W-1:0];
        dsr_nxt     = {dsr_r[CURRENT_W-2:0], trial_ge};
        step_nxt    = step_r + STEP_W'(1);
        if (step_r == STEP_W'(CURRENT_W - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (cnt_sum[CAP_W+1]) begin
          counter_nxt = '0;
        end else if (cnt_sum[CAP_W:0] > {1'b0, cfg_r.capacity}) begin
          counter_nxt = cfg_r.capacity;
        end else begin
          counter_nxt = cnt_sum[CAP_W-1:0];
        end
        held_nxt.pack_mv = (sum_r > SUM_W'(PACK_MV_MAX)) ? PACK_MV_MAX : sum_r[CELL_MV_W-1:0];
        soc_start_nxt    = 1'b1;
        state_nxt        = S_SOC;
      end
      S_SOC: begin
        if (soc_done) begin
          held_nxt.soc = soc_quo;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = bmon_make_result(held_r, cfg_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      soc_start_r    <= 1'b0;
      counter_r      <= RESET_COUNTER;
      held_r         <= '0;
      cfg_r.capacity       <= RESET_CAPACITY;
      cfg_r.chg_over_temp  <= RESET_CHG_OVER;
      cfg_r.chg_under_temp <= RESET_CHG_UNDER;
      cfg_r.dsg_over_temp  <= RESET_DSG_OVER;
      cfg_r.soc_full       <= RESET_SOC_FULL;
      cfg_r.soc_empty      <= RESET_SOC_EMPTY;
      cfg_r.chg_mask       <= RESET_CHG_MASK;
      cfg_r.dsg_mask       <= RESET_DSG_MASK;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      soc_start_r <= soc_start_nxt;
      counter_r   <= counter_nxt;
      held_r      <= held_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    cell_sr_r <= cell_sr_nxt;
    sum_r     <= sum_nxt;
    dsr_r     <= dsr_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
  end

  assign in_ch.ready         = state_r == S_IDLE;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pack_mv      = out_r.pack_mv;
  assign out_ch.soc_pct      = out_r.soc_pct;
  assign out_ch.avg_temp     = out_r.avg_temp;
  assign out_ch.max_temp     = out_r.max_temp;
  assign out_ch.pack_status  = out_r.pack_status;
  assign out_ch.charge_ok    = out_r.charge_ok;
  assign out_ch.discharge_ok = out_r.discharge_ok;
  assign out_ch.fault_active = out_r.fault_active;
  assign out_ch.state_valid  = out_r.state_valid;

endmodule

`default_nettype wire

[test/battery_coulomb_soc_monitor_unit_tb.sv]
`timescale 1ns / 1ps

module battery_coulomb_soc_monitor_unit_tb;
  import bmon_pkg::*;

  localparam int CELLS = 4;
  localparam int RANDOM_PHASES = 9;
  localparam int TICKS_PER_PHASE = 160;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int QUIET_LIMIT = 4000;
  localparam int BIAS_RUN = 40;

  typedef struct packed {
    logic                           afe_valid;
    logic [CELLS*CELL_MV_W-1:0]     cell_mv;
    logic signed [CURRENT_W-1:0]    pack_current;
    logic [FLAGS_W-1:0]             flags;
    logic                           temp_valid;
    logic signed [TEMP_W-1:0]       temp_a;
    logic signed [TEMP_W-1:0]       temp_b;
  } tick_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bmon_in_if #(.CELL_COUNT(CELLS)) in_ch ();
  bmon_out_if out_ch ();

  battery_coulomb_soc_monitor_unit #(.CELL_COUNT(CELLS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [CAP_W-1:0]         capacity_cfg = RESET_CAPACITY;
  logic signed [TEMP_W-1:0] chg_over_cfg = RESET_CHG_OVER;
  logic signed [TEMP_W-1:0] chg_under_cfg = RESET_CHG_UNDER;
  logic signed [TEMP_W-1:0] dsg_over_cfg = RESET_DSG_OVER;
  logic [SOC_W-1:0]         soc_full_cfg = RESET_SOC_FULL;
  logic [SOC_W-1:0]         soc_empty_cfg = RESET_SOC_EMPTY;
  logic [FLAGS_W-1:0]       chg_mask_cfg = RESET_CHG_MASK;
  logic [FLAGS_W-1:0]       dsg_mask_cfg = RESET_DSG_MASK;

  longint                   charge_mas = RESET_COUNTER;
  logic [CELL_MV_W-1:0]     pack_mv_now = '0;
  int                       current_now = 0;
  int                       avg_temp_now = 0;
  int                       max_temp_now = 0;
  int                       soc_now = 0;
  logic [FLAGS_W-1:0]       flags_now = '0;
  logic [STATUS_W-1:0]      status_now = STATUS_IDLE;
  logic                     valid_now = 1'b0;

  tick_t   pending_ticks[$];
  result_t expected_reports[$];
  tick_t   offered;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int current_bias = 1;
  int random_ticks = 0;
  int ticks_sent = 0;
  int reports_seen = 0;
  int mismatches = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t predict_report(tick_t t);
    result_t     r;
    int unsigned mv_sum;
    int          i;
    int          ta;
    int          tb;
    longint      cap;
    if (t.afe_valid) begin
      mv_sum = 0;
      for (i = 0; i < CELLS; i++) begin
        mv_sum += t.cell_mv[i*CELL_MV_W +: CELL_MV_W];
      end
      pack_mv_now = (mv_sum > PACK_MV_MAX) ? PACK_MV_MAX : mv_sum[CELL_MV_W-1:0];
      current_now = $signed(t.pack_current);
      flags_now = t.flags;
      if (t.temp_valid) begin
        ta = $signed(t.temp_a);
        tb = $signed(t.temp_b);
        avg_temp_now = (ta + tb) / 2;
        max_temp_now = (ta > tb) ? ta : tb;
      end
      cap = capacity_cfg;
      charge_mas += current_now / 10;
      if (charge_mas > cap) charge_mas = cap;
      if (charge_mas < 0) charge_mas = 0;
      soc_now = (cap > 0) ? int'((charge_mas * 100) / cap) : 0;
      if (flags_now != '0) begin
        status_now = STATUS_FAULT;
      end else if (current_now > int'(CURRENT_THRESHOLD)) begin
        status_now = STATUS_CHARGING;
      end else if (current_now < -int'(CURRENT_THRESHOLD)) begin
        status_now = STATUS_DISCHARGING;
      end else begin
        status_now = STATUS_IDLE;
      end
      valid_now = 1'b1;
    end else begin
      valid_now = 1'b0;
    end
    r.pack_mv = pack_mv_now;
    r.soc_pct = soc_now[SOC_W-1:0];
    r.avg_temp = avg_temp_now[TEMP_W-1:0];
    r.max_temp = max_temp_now[TEMP_W-1:0];
    r.pack_status = status_now;
    r.fault_active = (flags_now != '0);
    r.state_valid = valid_now;
    r.charge_ok = ((flags_now & chg_mask_cfg) == '0) && !(max_temp_now > int'(chg_over_cfg)) &&
                  !(avg_temp_now < int'(chg_under_cfg)) && !(soc_now >= int'(soc_full_cfg));
    r.discharge_ok = ((flags_now & dsg_mask_cfg) == '0) &&
                     !(max_temp_now > int'(dsg_over_cfg)) && !(soc_now <= int'(soc_empty_cfg));
    return r;
  endfunction

  function automatic void add_tick(bit afe, logic [CELLS*CELL_MV_W-1:0] cells, int ma,
                                   logic [FLAGS_W-1:0] flags, bit tv, int ta, int tb);
    tick_t t;
    t.afe_valid = afe;
    t.cell_mv = cells;
    t.pack_current = ma[CURRENT_W-1:0];
    t.flags = flags;
    t.temp_valid = tv;
    t.temp_a = ta[TEMP_W-1:0];
    t.temp_b = tb[TEMP_W-1:0];
    pending_ticks.push_back(t);
  endfunction

  function automatic void add_random_tick();
    logic [CELLS*CELL_MV_W-1:0] cells;
    logic [FLAGS_W-1:0]         flags;
    int                         ma;
    int                         ta;
    int                         tb;
    int                         i;
    for (i = 0; i < CELLS; i++) begin
      case ($urandom_range(9))
        0, 1: cells[i*CELL_MV_W +: CELL_MV_W] = CELL_MV_W'($urandom);
        2: cells[i*CELL_MV_W +: CELL_MV_W] = $urandom_range(1) ? PACK_MV_MAX : '0;
        default: cells[i*CELL_MV_W +: CELL_MV_W] = CELL_MV_W'($urandom_range(4300, 2500));
      endcase
    end
    if (random_ticks % BIAS_RUN == 0) current_bias = -current_bias;
    random_ticks++;
    case ($urandom_range(9))
      0, 1: ma = $signed(CURRENT_W'($urandom));
      2: begin
        case ($urandom_range(4))
          0: ma = 500;
          1: ma = 501;
          2: ma = 9;
          3: ma = 10;
          default: ma = 11;
        endcase
      end
      3, 4: ma = $urandom_range(1000);
      default: ma = $urandom_range(3000000);
    endcase
    if ((ma < 0) != (current_bias < 0) && $urandom_range(3) != 0) ma = -ma;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: flags = '0;
      11, 12, 13, 14, 15, 16: flags = FLAGS_W'(1 << $urandom_range(FLAGS_W - 1));
      default: flags = FLAGS_W'($urandom);
    endcase
    case ($urandom_range(9))
      0, 1: begin
        ta = $signed(TEMP_W'($urandom));
        tb = $signed(TEMP_W'($urandom));
      end
      2: begin
        ta = int'(chg_over_cfg) + int'($urandom_range(2)) - 1;
        tb = int'(dsg_over_cfg) + int'($urandom_range(2)) - 1;
      end
      3: begin
        ta = 2 * int'(chg_under_cfg) + int'($urandom_range(2)) - 1;
        tb = int'($urandom_range(1));
      end
      default: begin
        ta = int'($urandom_range(1000)) - 300;
        tb = int'($urandom_range(1000)) - 300;
      end
    endcase
    add_tick($urandom_range(99) < 88, cells, ma, flags, $urandom_range(99) < 80, ta, tb);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_CAPACITY:       capacity_cfg = data[CAP_W-1:0];
      CFG_CHG_OVER_TEMP:  chg_over_cfg = data[TEMP_W-1:0];
      CFG_CHG_UNDER_TEMP: chg_under_cfg = data[TEMP_W-1:0];
      CFG_DSG_OVER_TEMP:  dsg_over_cfg = data[TEMP_W-1:0];
      CFG_SOC_FULL:       soc_full_cfg = data[SOC_W-1:0];
      CFG_SOC_EMPTY:      soc_empty_cfg = data[SOC_W-1:0];
      CFG_CHG_MASK:       chg_mask_cfg = data[FLAGS_W-1:0];
      CFG_DSG_MASK:       dsg_mask_cfg = data[FLAGS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(int sel);
    logic [CAP_W-1:0] cap;
    int               co;
    int               cu;
    int               dov;
    int               fl;
    int               em;
    int               cm;
    int               dm;
    co = int'($urandom_range(800)) - 200;
    cu = int'($urandom_range(300)) - 200;
    dov = int'($urandom_range(900)) - 100;
    fl = $urandom_range(110, 40);
    em = $urandom_range(60);
    cm = $urandom_range(255);
    dm = $urandom_range(255);
    case (sel)
      0: begin
        cap = CAP_W'(5000000);
        co = 450; cu = 0; dov = 600; fl = 100; em = 5; cm = 7; dm = 56;
      end
      1: begin
        cap = 31'h7FFFFFFF;
        co = 32767; cu = -32768; dov = 32767; fl = 127; em = 0; cm = 0; dm = 0;
      end
      2: begin
        cap = CAP_W'(1);
        co = -32768; cu = 32767; dov = -32768; fl = 0; em = 127; cm = 255; dm = 255;
      end
      3: cap = '0;
      4: cap = CAP_W'(20000000);
      5: cap = CAP_W'(1000);
      6: cap = CAP_W'($urandom_range(50000000, 1));
      7: begin
        cap = RESET_CAPACITY;
        co = int'(RESET_CHG_OVER); cu = int'(RESET_CHG_UNDER); dov = int'(RESET_DSG_OVER);
        fl = int'(RESET_SOC_FULL); em = int'(RESET_SOC_EMPTY);
        cm = int'(RESET_CHG_MASK); dm = int'(RESET_DSG_MASK);
      end
      default: begin
        cap = CAP_W'($urandom_range(32'h7FFFFFFF, 1));
        co = $signed(TEMP_W'($urandom));
        cu = $signed(TEMP_W'($urandom));
        dov = $signed(TEMP_W'($urandom));
        fl = $urandom_range(127);
        em = $urandom_range(127);
      end
    endcase
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_CHG_OVER_TEMP, CFG_DATA_W'(co & 'hFFFF));
    write_reg(CFG_CHG_UNDER_TEMP, CFG_DATA_W'(cu & 'hFFFF));
    write_reg(CFG_DSG_OVER_TEMP, CFG_DATA_W'(dov & 'hFFFF));
    write_reg(CFG_SOC_FULL, CFG_DATA_W'(fl));
    write_reg(CFG_SOC_EMPTY, CFG_DATA_W'(em));
    write_reg(CFG_CHG_MASK, CFG_DATA_W'(cm));
    write_reg(CFG_DSG_MASK, CFG_DATA_W'(dm));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_ticks.size() != 0 || in_ch.valid || expected_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_reports.push_back(predict_report(offered));
        ticks_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_ticks.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.afe_valid <= offered.afe_valid;
          in_ch.cell_mv <= offered.cell_mv;
          in_ch.pack_current <= offered.pack_current;
          in_ch.protection_flags <= offered.flags;
          in_ch.temp_valid <= offered.temp_valid;
          in_ch.temp_a <= offered.temp_a;
          in_ch.temp_b <= offered.temp_b;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $error("report transaction arrived with no expectation pending");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("pack_mv", want.pack_mv, out_ch.pack_mv);
          check_field("soc_pct", want.soc_pct, out_ch.soc_pct);
          check_field("avg_temp", want.avg_temp, out_ch.avg_temp);
          check_field("max_temp", want.max_temp, out_ch.max_temp);
          check_field("pack_status", want.pack_status, out_ch.pack_status);
          check_field("charge_ok", want.charge_ok, out_ch.charge_ok);
          check_field("discharge_ok", want.discharge_ok, out_ch.discharge_ok);
          check_field("fault_active", want.fault_active, out_ch.fault_active);
          check_field("state_valid", want.state_valid, out_ch.state_valid);
        end
        if (reports_seen % 500 == 250) holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timed out with %0d reports still expected.", expected_reports.size());
        $display("battery_coulomb_soc_monitor_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.afe_valid = 1'b0;
    in_ch.cell_mv = '0;
    in_ch.pack_current = '0;
    in_ch.protection_flags = '0;
    in_ch.temp_valid = 1'b0;
    in_ch.temp_a = '0;
    in_ch.temp_b = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 31;
    recv_idle_pct = 73;

    add_tick(0, '0, 0, 8'h00, 0, 0, 0);
    add_tick(1, '0, 0, 8'h00, 1, 0, 0);
    add_tick(1, {CELLS{16'hFFFF}}, 8388607, 8'h00, 1, 32767, 32767);
    add_tick(1, {16'd16384, 16'd16384, 16'd16384, 16'd16383}, -8388608, 8'h00, 1,
             -32768, -32768);
    add_tick(1, {CELLS{16'd16384}}, 501, 8'h00, 1, 32767, -32768);
    add_tick(1, {CELLS{16'd3700}}, 500, 8'h00, 1, -3, 0);
    add_tick(1, {CELLS{16'd3650}}, -500, 8'h00, 1, 449, 451);
    add_tick(1, {CELLS{16'd3600}}, -501, 8'h00, 1, 600, 601);
    add_tick(1, {CELLS{16'd3900}}, 9, 8'h80, 1, 0, 0);
    add_tick(1, {CELLS{16'd4100}}, -9, 8'h01, 1, -1, -2);
    add_tick(1, {CELLS{16'd3300}}, -19, 8'h08, 1, 250, 260);
    add_tick(1, {CELLS{16'd3800}}, 10, 8'h00, 0, 999, 999);
    add_tick(0, {CELLS{16'd4000}}, 100000, 8'h3F, 1, 700, 700);
    add_tick(1, {CELLS{16'd3750}}, -11, 8'h40, 1, -1, -2);
    add_tick(1, {CELLS{16'd3750}}, 4000000, 8'h00, 1, 200, 220);
    add_tick(1, {CELLS{16'd3750}}, 8000000, 8'h00, 1, 200, 220);
    add_tick(1, {CELLS{16'd3750}}, -8000000, 8'h20, 0, 200, 220);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      load_setting(phase);
      @(negedge clk);
      send_idle_pct = (phase < 3) ? 31 : (phase < 6) ? 73 : 0;
      recv_idle_pct = (phase < 3) ? 73 : (phase < 6) ? 31 : 0;
      repeat (TICKS_PER_PHASE) add_random_tick();
    end
    wait_idle();

    $display("Sent %0d ticks and checked %0d reports over directed cases and %0d register settings,",
             ticks_sent, reports_seen, RANDOM_PHASES);
    $display("among them zero, unit and full-scale capacity, levels above 100 and a long output stall.");
    if (mismatches == 0) begin
      $display("battery_coulomb_soc_monitor_unit_tb: PASS");
    end else begin
      $display("battery_coulomb_soc_monitor_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/bmon_pkg.sv
hdl/bmon_if.sv
hdl/bmon_soc_div.sv
hdl/battery_coulomb_soc_monitor_unit.sv
test/battery_coulomb_soc_monitor_unit_tb.sv
